### rtl/core/msp_pkg.sv
// Shared types, constants and the CRC-8 step function for the message
// frame encoder. Used by every module of the block; no dependencies.
`default_nettype none

package msp_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned MAX_RUN   = 9;
    localparam int unsigned RUN_IDX_W = $clog2(MAX_RUN);
    localparam int unsigned RUN_CNT_W = $clog2(MAX_RUN + 1);
    localparam int unsigned S_TDATA_W = 56;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [7:0]  SYNC_CHAR     = 8'h24;
    localparam logic [7:0]  FLAG_BYTE     = 8'h00;
    localparam logic [7:0]  CRC_POLY      = 8'hD5;
    localparam logic [15:0] V1_MAX_LEN    = 16'd255;
    localparam logic [7:0]  V1_MAGIC_INIT = 8'd77;
    localparam logic [7:0]  V2_MAGIC_INIT = 8'd88;

    localparam logic [CFG_IDX_W-1:0] CFG_V1_MAGIC = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_V2_MAGIC = 1'b1;

    localparam logic FUNC_HEADER  = 1'b0;
    localparam logic FUNC_PAYLOAD = 1'b1;
    localparam logic VER_1        = 1'b0;
    localparam logic VER_2        = 1'b1;

    typedef struct packed {
        logic        func;
        logic        version;
        logic [7:0]  direction;
        logic [15:0] command;
        logic [15:0] length;
        logic [7:0]  data_byte;
    } item_t;

    typedef struct packed {
        logic [MAX_RUN-1:0][BYTE_W-1:0] bytes;
        logic [RUN_CNT_W-1:0]           count;
        logic                           eof;
    } run_t;

    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/msp_in_stage.sv
// Input register stage of the message frame encoder.
// Holds one accepted word until the framer takes it; uses msp_pkg.
`default_nettype none

module msp_in_stage (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           in_valid,
    output logic                in_ready,
    input  msp_pkg::item_t      in_item,
    input  wire logic           take,
    output logic                item_valid,
    output msp_pkg::item_t      item
);

    logic           valid_reg;
    logic           valid_next;
    msp_pkg::item_t item_reg;

    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_comb begin
        valid_next = valid_reg;
        if (in_valid && in_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            item_reg <= in_item;
        end
    end

endmodule

`default_nettype wire

### rtl/core/msp_framer.sv
// Frame state and byte generation: turns one word into its run of result bytes.
// Holds the magic registers and the checksum state; uses msp_pkg.
`default_nettype none

module msp_framer (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_we,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [7:0]                        cfg_wdata,
    input  wire logic                              take,
    input  msp_pkg::item_t                         item,
    output msp_pkg::run_t                          run
);

    logic [7:0]  v1_magic_reg;
    logic [7:0]  v2_magic_reg;
    logic        in_frame_reg;
    logic        in_frame_next;
    logic        frame_version_reg;
    logic        frame_version_next;
    logic        dropping_reg;
    logic        dropping_next;
    logic [15:0] bytes_left_reg;
    logic [15:0] bytes_left_next;
    logic [7:0]  check_reg;
    logic [7:0]  check_next;

    logic [7:0]  cmd_lo;
    logic [7:0]  cmd_hi;
    logic [7:0]  len_lo;
    logic [7:0]  len_hi;
    logic [7:0]  v1_hdr_check;
    logic [7:0]  v2_hdr_check;
    logic [7:0]  data_check;
    logic [15:0] left_dec;

    assign cmd_lo   = item.command[7:0];
    assign cmd_hi   = item.command[15:8];
    assign len_lo   = item.length[7:0];
    assign len_hi   = item.length[15:8];
    assign left_dec = bytes_left_reg - 16'd1;

    assign v1_hdr_check = len_lo ^ cmd_lo;
    assign v2_hdr_check = msp_pkg::crc8_step(msp_pkg::crc8_step(msp_pkg::crc8_step(
                          msp_pkg::crc8_step(msp_pkg::crc8_step(8'h00, msp_pkg::FLAG_BYTE),
                          cmd_lo), cmd_hi), len_lo), len_hi);
    assign data_check   = frame_version_reg ? msp_pkg::crc8_step(check_reg, item.data_byte)
                                            : (check_reg ^ item.data_byte);

    always_comb begin
        run                = '0;
        in_frame_next      = in_frame_reg;
        frame_version_next = frame_version_reg;
        dropping_next      = dropping_reg;
        bytes_left_next    = bytes_left_reg;
        check_next         = check_reg;
        if (item.func == msp_pkg::FUNC_HEADER) begin
            in_frame_next      = 1'b1;
            frame_version_next = item.version;
            dropping_next      = 1'b0;
            bytes_left_next    = item.length;
            if (item.version == msp_pkg::VER_1) begin
                check_next = v1_hdr_check;
                if (item.length >= msp_pkg::V1_MAX_LEN) begin
                    dropping_next = 1'b1;
                end else begin
                    run.bytes[0] = msp_pkg::SYNC_CHAR;
                    run.bytes[1] = v1_magic_reg;
                    run.bytes[2] = item.direction;
                    run.bytes[3] = len_lo;
                    run.bytes[4] = cmd_lo;
                    run.count    = msp_pkg::RUN_CNT_W'(5);
                    if (item.length == 16'd0) begin
                        run.bytes[5]  = v1_hdr_check;
                        run.count     = msp_pkg::RUN_CNT_W'(6);
                        run.eof       = 1'b1;
                        in_frame_next = 1'b0;
                    end
                end
            end else begin
                check_next   = v2_hdr_check;
                run.bytes[0] = msp_pkg::SYNC_CHAR;
                run.bytes[1] = v2_magic_reg;
                run.bytes[2] = item.direction;
                run.bytes[3] = msp_pkg::FLAG_BYTE;
                run.bytes[4] = cmd_lo;
                run.bytes[5] = cmd_hi;
                run.bytes[6] = len_lo;
                run.bytes[7] = len_hi;
                run.count    = msp_pkg::RUN_CNT_W'(8);
                if (item.length == 16'd0) begin
                    run.bytes[8]  = v2_hdr_check;
                    run.count     = msp_pkg::RUN_CNT_W'(9);
                    run.eof       = 1'b1;
                    in_frame_next = 1'b0;
                end
            end
        end else if (in_frame_reg) begin
            bytes_left_next = left_dec;
            if (dropping_reg) begin
                if (left_dec == 16'd0) begin
                    dropping_next = 1'b0;
                    in_frame_next = 1'b0;
                end
            end else begin
                check_next   = data_check;
                run.bytes[0] = item.data_byte;
                run.count    = msp_pkg::RUN_CNT_W'(1);
                if (left_dec == 16'd0) begin
                    run.bytes[1]  = data_check;
                    run.count     = msp_pkg::RUN_CNT_W'(2);
                    run.eof       = 1'b1;
                    in_frame_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_magic_reg      <= msp_pkg::V1_MAGIC_INIT;
            v2_magic_reg      <= msp_pkg::V2_MAGIC_INIT;
            in_frame_reg      <= 1'b0;
            frame_version_reg <= 1'b0;
            dropping_reg      <= 1'b0;
            bytes_left_reg    <= 16'd0;
            check_reg         <= 8'd0;
        end else begin
            if (cfg_we && (cfg_index == msp_pkg::CFG_V1_MAGIC)) begin
                v1_magic_reg <= cfg_wdata;
            end
            if (cfg_we && (cfg_index == msp_pkg::CFG_V2_MAGIC)) begin
                v2_magic_reg <= cfg_wdata;
            end
            if (take) begin
                in_frame_reg      <= in_frame_next;
                frame_version_reg <= frame_version_next;
                dropping_reg      <= dropping_next;
                bytes_left_reg    <= bytes_left_next;
                check_reg         <= check_next;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/core/msp_out_buf.sv
// Result register of the message frame encoder: holds one run of bytes and
// sends them one word per handshake. Uses msp_pkg.
`default_nettype none

module msp_out_buf (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      load,
    input  msp_pkg::run_t  run,
    output logic           free,
    output logic           out_valid,
    input  wire logic      out_ready,
    output logic [7:0]     out_byte,
    output logic           out_eof,
    output logic           out_last
);

    msp_pkg::run_t                   run_reg;
    logic                            valid_reg;
    logic                            valid_next;
    logic [msp_pkg::RUN_IDX_W-1:0]   idx_reg;
    logic [msp_pkg::RUN_IDX_W-1:0]   idx_next;
    logic                            is_last;

    assign is_last   = (msp_pkg::RUN_CNT_W'(idx_reg) + 1'b1) == run_reg.count;
    assign free      = !valid_reg || (out_ready && is_last);
    assign out_valid = valid_reg;
    assign out_byte  = run_reg.bytes[idx_reg];
    assign out_last  = is_last;
    assign out_eof   = run_reg.eof && is_last;

    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load) begin
            valid_next = (run.count != '0);
            idx_next   = '0;
        end else if (valid_reg && out_ready) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            run_reg <= run;
        end
    end

endmodule

`default_nettype wire

### rtl/core/msp_frame_encoder.sv
// Top level of the message frame encoder (version 1 and version 2 framing).
// Instantiates msp_in_stage, msp_framer and msp_out_buf; uses msp_pkg.
//
// Usage: each input word is either a header (s_tuser low) that opens a frame
// or a payload byte (s_tuser high). The block answers with a run of output
// words, one frame byte each: a header gives 5 or 8 bytes (plus the checksum
// when the length is zero), a payload byte gives itself and, on the last one,
// the checksum. m_tlast marks the last word of a run, m_tuser the checksum.
// Some words give no output (dropped long version 1 frames, stray payload).
// A word is registered on input and its run is formed from it into the
// result register, from which the first byte goes to the result port.
// Throughput: one input word per cycle while each run is one byte long and
// the receiver does not stall; a longer run holds the result register until
// its last byte goes, and the input register takes one more word meanwhile.
// Reset clears the frame state, both channels and restores the magic bytes.
// When the receiver stalls, the current byte holds and input fills and stops.
// Magic registers are written through cfg_we, cfg_index and cfg_wdata.
`default_nettype none

module msp_frame_encoder (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // version[0], direction[8:1], command[24:9], length[40:25],
    // data_byte[48:41], zero fill above
    input  wire logic [msp_pkg::S_TDATA_W-1:0]      s_tdata,
    // func[0]
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // out_byte[7:0]
    output logic [7:0]                              m_tdata,
    // end_of_frame[0]
    output logic                                    m_tuser,
    output logic                                    m_tlast,
    input  wire logic                               cfg_we,
    input  wire logic [msp_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [7:0]                         cfg_wdata
);

    msp_pkg::item_t in_item;
    msp_pkg::item_t item;
    msp_pkg::run_t  run;
    logic           item_valid;
    logic           free;
    logic           take;

    assign in_item.func      = s_tuser;
    assign in_item.version   = s_tdata[0];
    assign in_item.direction = s_tdata[8:1];
    assign in_item.command   = s_tdata[24:9];
    assign in_item.length    = s_tdata[40:25];
    assign in_item.data_byte = s_tdata[48:41];

    assign take = item_valid && free;

    msp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    msp_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .item      (item),
        .run       (run)
    );

    msp_out_buf u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (take),
        .run       (run),
        .free      (free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_byte  (m_tdata),
        .out_eof   (m_tuser),
        .out_last  (m_tlast)
    );

endmodule

`default_nettype wire

### rtl/core/msp_frame_encoder_checker.sv
// Port-level checks of the message frame encoder and their bind statement.
// Depends on msp_frame_encoder.
`default_nettype none

module msp_frame_encoder_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tuser,
    input wire logic       m_tlast
);

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("output word dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
        else $error("output word changed while stalled");

    a_eof_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("checksum word is not the last word of its run");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("channels not idle after reset");

endmodule

bind msp_frame_encoder msp_frame_encoder_checker u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire

### tb/msp_frame_checker.sv
// Checker for the message frame encoder: watches the input, output and
// register-write ports, predicts every output word and compares them in order.
// Depends on msp_pkg for the field widths and the protocol constants.
`default_nettype none

module msp_frame_checker
    import msp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  s_tvalid,
    input  wire logic                  s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    input  wire logic                  s_tuser,
    input  wire logic                  m_tvalid,
    input  wire logic                  m_tready,
    input  wire logic [7:0]            m_tdata,
    input  wire logic                  m_tuser,
    input  wire logic                  m_tlast,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [7:0]            cfg_wdata,
    output int                         fail_count,
    output int                         pending,
    output int                         bytes_checked,
    output int                         frames_closed
);

    typedef struct packed {
        logic [7:0] value;
        logic       eof;
        logic       last;
    } frame_byte_t;

    frame_byte_t expected_bytes[$];

    logic [7:0]  v1_magic_q;
    logic [7:0]  v2_magic_q;
    logic        in_frame;
    logic        frame_v2;
    logic        dropping;
    logic [15:0] bytes_left;
    logic [7:0]  check_q;
    int          run_len;

    function automatic logic [7:0] crc8_dvb(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] r;
        r = crc ^ b;
        repeat (8) begin
            r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
        end
        return r;
    endfunction

    task automatic report(input string field, input logic [7:0] got, input logic [7:0] want);
        $display("[%0t] mismatch on %s: got %02h, expected %02h", $time, field, got, want);
        fail_count++;
    endtask

    task automatic emit(input logic [7:0] value, input logic eof);
        expected_bytes.push_back('{value: value, eof: eof, last: 1'b0});
        run_len++;
    endtask

    task automatic fold(input logic [7:0] b);
        check_q = frame_v2 ? crc8_dvb(check_q, b) : (check_q ^ b);
    endtask

    task automatic close_frame();
        emit(check_q, 1'b1);
        in_frame = 1'b0;
    endtask

    task automatic encode_word(input logic func, input logic [S_TDATA_W-1:0] word);
        logic        ver;
        logic [7:0]  dir;
        logic [15:0] cmd;
        logic [15:0] len;
        logic [7:0]  data;
        ver  = word[0];
        dir  = word[8:1];
        cmd  = word[24:9];
        len  = word[40:25];
        data = word[48:41];
        if (func == FUNC_HEADER) begin
            in_frame   = 1'b1;
            frame_v2   = (ver == VER_2);
            dropping   = 1'b0;
            bytes_left = len;
            check_q    = 8'h00;
            if (ver == VER_1) begin
                if (len >= V1_MAX_LEN) begin
                    dropping = 1'b1;
                    return;
                end
                emit(SYNC_CHAR, 1'b0);
                emit(v1_magic_q, 1'b0);
                emit(dir, 1'b0);
                emit(len[7:0], 1'b0);
                emit(cmd[7:0], 1'b0);
                fold(len[7:0]);
                fold(cmd[7:0]);
            end else begin
                emit(SYNC_CHAR, 1'b0);
                emit(v2_magic_q, 1'b0);
                emit(dir, 1'b0);
                emit(FLAG_BYTE, 1'b0);
                emit(cmd[7:0], 1'b0);
                emit(cmd[15:8], 1'b0);
                emit(len[7:0], 1'b0);
                emit(len[15:8], 1'b0);
                fold(FLAG_BYTE);
                fold(cmd[7:0]);
                fold(cmd[15:8]);
                fold(len[7:0]);
                fold(len[15:8]);
            end
            if (len == 16'd0) close_frame();
        end else begin
            if (!in_frame) return;
            if (dropping) begin
                bytes_left--;
                if (bytes_left == 16'd0) begin
                    dropping = 1'b0;
                    in_frame = 1'b0;
                end
                return;
            end
            emit(data, 1'b0);
            fold(data);
            bytes_left--;
            if (bytes_left == 16'd0) close_frame();
        end
    endtask

    always @(posedge aclk) begin
        frame_byte_t want;
        if (!aresetn) begin
            expected_bytes.delete();
            v1_magic_q    = V1_MAGIC_INIT;
            v2_magic_q    = V2_MAGIC_INIT;
            in_frame      = 1'b0;
            frame_v2      = 1'b0;
            dropping      = 1'b0;
            bytes_left    = 16'd0;
            check_q       = 8'h00;
            fail_count    = 0;
            bytes_checked = 0;
            frames_closed = 0;
        end else begin
            if (cfg_we) begin
                if (cfg_index == CFG_V1_MAGIC) v1_magic_q = cfg_wdata;
                else if (cfg_index == CFG_V2_MAGIC) v2_magic_q = cfg_wdata;
            end
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    $display("[%0t] unexpected output word %02h", $time, m_tdata);
                    fail_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want.value) report("byte", m_tdata, want.value);
                    if (m_tuser !== want.eof)
                        report("end of frame", {7'b0, m_tuser}, {7'b0, want.eof});
                    if (m_tlast !== want.last)
                        report("last in run", {7'b0, m_tlast}, {7'b0, want.last});
                    bytes_checked++;
                    if (want.eof) frames_closed++;
                end
            end
            if (s_tvalid && s_tready) begin
                run_len = 0;
                encode_word(s_tuser, s_tdata);
                if (run_len > 0) begin
                    want = expected_bytes.pop_back();
                    want.last = 1'b1;
                    expected_bytes.push_back(want);
                end
            end
        end
        pending <= expected_bytes.size();
    end

endmodule

`default_nettype wire

### tb/testbench.sv
// Top of the frame encoder testbench: clock, reset, stimulus and verdict.
// Instantiates msp_frame_encoder and msp_frame_checker; uses msp_pkg.
`default_nettype none

module testbench;
    import msp_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE_TICKS = 8;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    // version[0], direction[8:1], command[24:9], length[40:25],
    // data_byte[48:41], zero fill above
    logic [S_TDATA_W-1:0] s_tdata   = '0;
    // func[0]
    logic                 s_tuser   = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    // out_byte[7:0]
    logic [7:0]           m_tdata;
    // end_of_frame[0]
    logic                 m_tuser;
    logic                 m_tlast;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [7:0]           cfg_wdata = 8'h00;

    int fail_count;
    int pending;
    int bytes_checked;
    int frames_closed;
    int cycles      = 0;
    int words_sent  = 0;
    int stall_left  = 0;
    bit hold_req    = 1'b0;
    bit calm        = 1'b0;

    msp_frame_encoder uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    msp_frame_checker chk (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .m_tlast       (m_tlast),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .fail_count    (fail_count),
        .pending       (pending),
        .bytes_checked (bytes_checked),
        .frames_closed (frames_closed)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Run stopped after %0d cycles with %0d words outstanding.", cycles, pending);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 95) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver: random stalls, a long hold-off on request, none while calm.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(99) < 25) begin
                stall_left = pick_gap() - 1;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_word(input logic func, input logic ver, input logic [7:0] dir,
                             input logic [15:0] cmd, input logic [15:0] len,
                             input logic [7:0] data);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {7'b0, data, len, cmd, dir, ver};
        do @(posedge aclk); while (!s_tready);
        words_sent++;
        if (!calm && $urandom_range(99) < 30) begin
            gap = pick_gap();
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic header(input logic ver, input logic [15:0] len);
        send_word(FUNC_HEADER, ver, 8'($urandom_range(255)), 16'($urandom_range(65535)), len,
                  8'($urandom_range(255)));
    endtask

    task automatic payload(input logic [7:0] data);
        send_word(FUNC_PAYLOAD, 1'($urandom_range(1)), 8'($urandom_range(255)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)), data);
    endtask

    task automatic frame(input logic ver, input int len);
        header(ver, len[15:0]);
        repeat (len) payload(8'($urandom_range(255)));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic int frame_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 0;
        if (r < 85) return $urandom_range(1, 8);
        return $urandom_range(9, 40);
    endfunction

    // Mostly complete frames; the rest abandoned, swallowed or stray words.
    task automatic random_traffic(input int target);
        int n;
        int len;
        int k;
        int r;
        n = 0;
        while (n < target) begin
            r = $urandom_range(99);
            if (r < 78) begin
                len = frame_len();
                frame(1'($urandom_range(1)), len);
                n += len + 1;
            end else if (r < 86) begin
                len = $urandom_range(2, 20);
                k = $urandom_range(len - 1);
                header(1'($urandom_range(1)), len[15:0]);
                repeat (k) payload(8'($urandom_range(255)));
                n += k + 1;
            end else if (r < 92) begin
                len = $urandom_range(0, 4);
                frame(1'($urandom_range(1)), len);
                repeat ($urandom_range(1, 3)) payload(8'($urandom_range(255)));
                n += len + 1;
            end else if (r < 96) begin
                len = $urandom_range(255, 258);
                header(VER_1, len[15:0]);
                k = $urandom_range(5);
                repeat (k) payload(8'($urandom_range(255)));
                n += k + 1;
            end else begin
                header(VER_2, 16'($urandom_range(256, 65535)));
                k = $urandom_range(5);
                repeat (k) payload(8'($urandom_range(255)));
                n += k + 1;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part, reset values of the magic bytes.
        send_word(FUNC_HEADER, VER_1, 8'hFF, 16'hFFFF, 16'h0000, 8'hFF);
        send_word(FUNC_HEADER, VER_2, 8'h00, 16'h0000, 16'h0000, 8'h00);
        send_word(FUNC_HEADER, VER_2, 8'hFF, 16'hFFFF, 16'hFFFF, 8'h00);
        payload(8'hFF);
        payload(8'h00);
        send_word(FUNC_HEADER, VER_1, 8'h3C, 16'h1234, 16'd254, 8'hA5);
        payload(8'h00);
        send_word(FUNC_HEADER, VER_1, 8'h3E, 16'h0042, 16'd255, 8'h5A);
        payload(8'hFF);
        payload(8'h00);
        send_word(FUNC_HEADER, VER_1, 8'h3E, 16'hFF00, 16'hFFFF, 8'h00);
        payload(8'h12);
        send_word(FUNC_HEADER, VER_1, 8'h3E, 16'h00B6, 16'd3, 8'h00);
        payload(8'hFF);
        payload(8'h00);
        payload(8'hA5);
        payload(8'h77);
        payload(8'h88);
        send_word(FUNC_HEADER, VER_2, 8'h3C, 16'h8001, 16'd2, 8'hFF);
        payload(8'hFF);
        payload(8'h00);
        send_word(FUNC_HEADER, VER_1, 8'h24, 16'h0001, 16'd1, 8'h00);
        payload(8'h5A);
        settle();

        write_reg(CFG_V1_MAGIC, 8'hFF);
        write_reg(CFG_V2_MAGIC, 8'h00);
        random_traffic(70);
        settle();

        write_reg(CFG_V1_MAGIC, 8'h00);
        write_reg(CFG_V2_MAGIC, 8'hFF);
        // The receiver holds off while the sender keeps offering words.
        hold_req = 1'b1;
        calm     = 1'b1;
        frame(VER_2, 30);
        calm     = 1'b0;
        settle();
        random_traffic(70);
        settle();

        write_reg(CFG_V1_MAGIC, 8'($urandom_range(255)));
        write_reg(CFG_V2_MAGIC, 8'($urandom_range(255)));
        calm = 1'b1;
        random_traffic(50);
        settle();

        $display("Sent %0d input words over four magic settings; checked %0d output bytes,",
                 words_sent, bytes_checked);
        $display("%0d frames closed, with stalls, a long hold-off and gap-free stretches.",
                 frames_closed);
        if (fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
